// ===== design/biou_pkg.sv =====
// shared constants for the box intersection-over-union pipeline
package biou_pkg;

  // ratio format: unsigned q0.16 with room for exactly one
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned IOU_BITS  = FRAC_BITS + 1;

  localparam logic [IOU_BITS-1:0] IOU_ONE  = IOU_BITS'(1) << FRAC_BITS;
  localparam logic [IOU_BITS-1:0] IOU_ZERO = '0;

endpackage

// ===== design/biou_div_step.sv =====
// one restoring-division step: shift in a dividend bit, trial subtract
module biou_div_step
  import biou_pkg::*;
#(
  parameter int unsigned UW = 25
) (
  input  logic [UW-1:0] rem_i,
  input  logic          bit_i,
  input  logic [UW-1:0] divisor_i,
  output logic [UW-1:0] rem_o,
  output logic          q_o
);

  logic [UW:0] shifted;
  logic [UW:0] diff;

  always_comb begin
    shifted = {rem_i, bit_i};
    diff    = shifted - {1'b0, divisor_i};
    q_o     = (shifted >= {1'b0, divisor_i});
    // remainder stays below the divisor, so it fits back in uw bits
    rem_o   = q_o ? diff[UW-1:0] : shifted[UW-1:0];
  end

endmodule

// ===== design/box_intersection_over_union_unit.sv =====
// box intersection-over-union unit: pipelined geometry, areas and q0.16 ratio
// each accepted request passes through 5 + IOU_BITS register stages to its result
// throughput: one request per cycle unless the output stalls; 5 geometry/area/dividend stages feed a divider
// that resolves one quotient bit per stage, 17 stages in all
// a stalled output holds only the stages behind it that are full; bubbles close up
// reset clears the stage valid bits only; data registers are not reset
module box_intersection_over_union_unit
  import biou_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [COORD_BITS-1:0]     a_x_i,
  input  logic [COORD_BITS-1:0]     a_y_i,
  input  logic [COORD_BITS-1:0]     a_w_i,
  input  logic [COORD_BITS-1:0]     a_h_i,
  input  logic [COORD_BITS-1:0]     b_x_i,
  input  logic [COORD_BITS-1:0]     b_y_i,
  input  logic [COORD_BITS-1:0]     b_w_i,
  input  logic [COORD_BITS-1:0]     b_h_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [COORD_BITS-1:0]     inter_x_o,
  output logic [COORD_BITS-1:0]     inter_y_o,
  output logic [COORD_BITS-1:0]     inter_w_o,
  output logic [COORD_BITS-1:0]     inter_h_o,
  output logic [COORD_BITS-1:0]     hull_x_o,
  output logic [COORD_BITS-1:0]     hull_y_o,
  output logic [COORD_BITS:0]       hull_w_o,
  output logic [COORD_BITS:0]       hull_h_o,
  output logic [2*COORD_BITS-1:0]   inter_area_o,
  output logic [2*COORD_BITS:0]     union_area_o,
  output logic [IOU_BITS-1:0]       iou_q16_o
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned AW = 2 * CB;
  localparam int unsigned UW = 2 * CB + 1;
  localparam int unsigned NW = AW + IOU_BITS;
  localparam int unsigned NS = 5 + IOU_BITS;

  typedef struct packed {
    logic [CB-1:0] lo_x;
    logic [CB-1:0] lo_y;
    logic [CB:0]   hi_x;
    logic [CB:0]   hi_y;
    logic [CB-1:0] hx;
    logic [CB-1:0] hy;
    logic [CB:0]   mx_r;
    logic [CB:0]   mx_b;
    logic [AW-1:0] area_a;
    logic [AW-1:0] area_b;
  } edge_t;

  typedef struct packed {
    logic [CB-1:0] ix;
    logic [CB-1:0] iy;
    logic [CB-1:0] iw;
    logic [CB-1:0] ih;
    logic [CB-1:0] hx;
    logic [CB-1:0] hy;
    logic [CB:0]   hw;
    logic [CB:0]   hh;
  } box_t;

  typedef struct packed {
    box_t          box;
    logic [UW-1:0] sum_ab;
  } st2_t;

  typedef struct packed {
    box_t          box;
    logic [UW-1:0] sum_ab;
    logic [AW-1:0] inter_area;
  } st3_t;

  typedef struct packed {
    box_t          box;
    logic [AW-1:0] inter_area;
    logic [UW-1:0] union_area;
  } st4_t;

  typedef struct packed {
    box_t                box;
    logic [AW-1:0]       inter_area;
    logic [UW-1:0]       union_area;
    logic [UW-1:0]       rem;
    logic [IOU_BITS-1:0] nlo;
    logic [IOU_BITS-1:0] q;
  } div_t;

  logic [NS-1:0] v_q, v_d, rdy, prev_v, en;

  edge_t s1_q, s1_d;
  st2_t  s2_q, s2_d;
  st3_t  s3_q, s3_d;
  st4_t  s4_q, s4_d;
  div_t  dv_q [IOU_BITS+1];
  div_t  dv_d [IOU_BITS+1];

  // a stage may load unless it and everything downstream is full and the output stalls
  always_comb begin
    for (int s = 0; s < NS; s++) begin
      rdy[s] = !out_stall_i || !(&((v_q >> s) | ~(~{NS{1'b0}} >> s)));
    end
    prev_v = {v_q[NS-2:0], in_valid_i};
    en     = rdy & prev_v;
    v_d    = (rdy & prev_v) | (~rdy & v_q);
  end

  assign in_stall_o = !rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // stage 1: box edges, overlap bounds, hull bounds, box areas
  logic [CB:0] a_r, a_b, b_r, b_b;

  always_comb begin
    a_r = {1'b0, a_x_i} + {1'b0, a_w_i};
    a_b = {1'b0, a_y_i} + {1'b0, a_h_i};
    b_r = {1'b0, b_x_i} + {1'b0, b_w_i};
    b_b = {1'b0, b_y_i} + {1'b0, b_h_i};
    s1_d.lo_x   = (a_x_i > b_x_i) ? a_x_i : b_x_i;
    s1_d.lo_y   = (a_y_i > b_y_i) ? a_y_i : b_y_i;
    s1_d.hx     = (a_x_i < b_x_i) ? a_x_i : b_x_i;
    s1_d.hy     = (a_y_i < b_y_i) ? a_y_i : b_y_i;
    s1_d.hi_x   = (a_r < b_r) ? a_r : b_r;
    s1_d.hi_y   = (a_b < b_b) ? a_b : b_b;
    s1_d.mx_r   = (a_r > b_r) ? a_r : b_r;
    s1_d.mx_b   = (a_b > b_b) ? a_b : b_b;
    s1_d.area_a = AW'(a_w_i) * AW'(a_h_i);
    s1_d.area_b = AW'(b_w_i) * AW'(b_h_i);
  end

  // stage 2: intersection box (zeroed when empty), hull size, sum of areas
  logic       nonempty;
  logic [CB:0] dx, dy;

  always_comb begin
    nonempty = (s1_q.hi_x > {1'b0, s1_q.lo_x}) && (s1_q.hi_y > {1'b0, s1_q.lo_y});
    dx       = s1_q.hi_x - {1'b0, s1_q.lo_x};
    dy       = s1_q.hi_y - {1'b0, s1_q.lo_y};
    s2_d.box.ix = nonempty ? s1_q.lo_x : '0;
    s2_d.box.iy = nonempty ? s1_q.lo_y : '0;
    s2_d.box.iw = nonempty ? dx[CB-1:0] : '0;
    s2_d.box.ih = nonempty ? dy[CB-1:0] : '0;
    s2_d.box.hx = s1_q.hx;
    s2_d.box.hy = s1_q.hy;
    s2_d.box.hw = s1_q.mx_r - {1'b0, s1_q.hx};
    s2_d.box.hh = s1_q.mx_b - {1'b0, s1_q.hy};
    s2_d.sum_ab = {1'b0, s1_q.area_a} + {1'b0, s1_q.area_b};
  end

  // stage 3: intersection area
  always_comb begin
    s3_d.box        = s2_q.box;
    s3_d.sum_ab     = s2_q.sum_ab;
    s3_d.inter_area = AW'(s2_q.box.iw) * AW'(s2_q.box.ih);
  end

  // stage 4: union area
  always_comb begin
    s4_d.box        = s3_q.box;
    s4_d.inter_area = s3_q.inter_area;
    s4_d.union_area = s3_q.sum_ab - {1'b0, s3_q.inter_area};
  end

  // stage 5: rounded dividend inter * 2^16 + union / 2, split for the divider
  logic [NW-1:0] dividend;

  always_comb begin
    dividend = (NW'(s4_q.inter_area) << FRAC_BITS) + NW'(s4_q.union_area >> 1);
    dv_d[0].box        = s4_q.box;
    dv_d[0].inter_area = s4_q.inter_area;
    dv_d[0].union_area = s4_q.union_area;
    dv_d[0].rem        = UW'(dividend[NW-1:IOU_BITS]);
    dv_d[0].nlo        = dividend[IOU_BITS-1:0];
    dv_d[0].q          = '0;
  end

  // divider stages, msb of the quotient first
  for (genvar k = 0; k < IOU_BITS; k++) begin : g_div
    logic [UW-1:0]       rem_nx;
    logic                q_bit;
    logic [IOU_BITS-1:0] q_nx;

    biou_div_step #(.UW(UW)) u_step (
      .rem_i     (dv_q[k].rem),
      .bit_i     (dv_q[k].nlo[IOU_BITS-1-k]),
      .divisor_i (dv_q[k].union_area),
      .rem_o     (rem_nx),
      .q_o       (q_bit)
    );

    always_comb begin
      q_nx                 = {dv_q[k].q[IOU_BITS-2:0], q_bit};
      dv_d[k+1].box        = dv_q[k].box;
      dv_d[k+1].inter_area = dv_q[k].inter_area;
      dv_d[k+1].union_area = dv_q[k].union_area;
      dv_d[k+1].rem        = rem_nx;
      dv_d[k+1].nlo        = dv_q[k].nlo;
      // empty union gives a zero ratio
      if ((k == IOU_BITS - 1) && (dv_q[k].union_area == '0)) begin
        dv_d[k+1].q = IOU_ZERO;
      end else begin
        dv_d[k+1].q = q_nx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_q <= s1_d;
    end
    if (en[1]) begin
      s2_q <= s2_d;
    end
    if (en[2]) begin
      s3_q <= s3_d;
    end
    if (en[3]) begin
      s4_q <= s4_d;
    end
    for (int k = 0; k <= IOU_BITS; k++) begin
      if (en[4+k]) begin
        dv_q[k] <= dv_d[k];
      end
    end
  end

  assign out_valid_o  = v_q[NS-1];
  assign inter_x_o    = dv_q[IOU_BITS].box.ix;
  assign inter_y_o    = dv_q[IOU_BITS].box.iy;
  assign inter_w_o    = dv_q[IOU_BITS].box.iw;
  assign inter_h_o    = dv_q[IOU_BITS].box.ih;
  assign hull_x_o     = dv_q[IOU_BITS].box.hx;
  assign hull_y_o     = dv_q[IOU_BITS].box.hy;
  assign hull_w_o     = dv_q[IOU_BITS].box.hw;
  assign hull_h_o     = dv_q[IOU_BITS].box.hh;
  assign inter_area_o = dv_q[IOU_BITS].inter_area;
  assign union_area_o = dv_q[IOU_BITS].union_area;
  assign iou_q16_o    = dv_q[IOU_BITS].q;

endmodule

// ===== design/biou_checker.sv =====
// port-level checks for the box intersection-over-union unit, with bind
module biou_checker
  import biou_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic [COORD_BITS-1:0]     a_x_i,
  input logic [COORD_BITS-1:0]     a_y_i,
  input logic [COORD_BITS-1:0]     a_w_i,
  input logic [COORD_BITS-1:0]     a_h_i,
  input logic [COORD_BITS-1:0]     b_x_i,
  input logic [COORD_BITS-1:0]     b_y_i,
  input logic [COORD_BITS-1:0]     b_w_i,
  input logic [COORD_BITS-1:0]     b_h_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [COORD_BITS-1:0]     inter_x_o,
  input logic [COORD_BITS-1:0]     inter_y_o,
  input logic [COORD_BITS-1:0]     inter_w_o,
  input logic [COORD_BITS-1:0]     inter_h_o,
  input logic [COORD_BITS-1:0]     hull_x_o,
  input logic [COORD_BITS-1:0]     hull_y_o,
  input logic [COORD_BITS:0]       hull_w_o,
  input logic [COORD_BITS:0]       hull_h_o,
  input logic [2*COORD_BITS-1:0]   inter_area_o,
  input logic [2*COORD_BITS:0]     union_area_o,
  input logic [IOU_BITS-1:0]       iou_q16_o
);

  // a stalled result keeps its value and its ratio
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(iou_q16_o)
      && $stable(union_area_o) && $stable(hull_w_o))
    else $error("stalled result changed");

  // empty overlap reports a zero intersection box and area
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (inter_w_o == '0 || inter_h_o == '0)
      |-> inter_x_o == '0 && inter_y_o == '0 && inter_area_o == '0)
    else $error("empty overlap not zeroed");

  // intersection cannot exceed union, so the ratio stays at or below one
  a_ratio_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, inter_area_o} <= union_area_o) && (iou_q16_o <= IOU_ONE))
    else $error("ratio or areas out of range");

  // zero union gives zero ratio
  a_zero_union: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && union_area_o == '0 |-> iou_q16_o == IOU_ZERO)
    else $error("nonzero ratio on empty union");

endmodule

bind box_intersection_over_union_unit biou_checker #(.COORD_BITS(COORD_BITS)) u_biou_checker (.*);
